### hw/rtl/mips_subset_single_cycle_core_unit_macros.svh
// ----------------------------------------------------------------------------
// MIPS subset core assertion macros
// Shorthand for the clocked, reset-qualified checks used by the core.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_UNIT_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSCC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSCC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mscc_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset core package
// Memory geometry, instruction codes and the structs shared by the core.
// ----------------------------------------------------------------------------
package mscc_pkg;

    // Data memory size in bytes; a power of two from 256 to 65536.
    localparam int DATA_MEM_BYTES = 65536;
    localparam int MEM_ADDR_W     = $clog2(DATA_MEM_BYTES);
    // The memory is split into four byte banks, one per byte lane.
    localparam int BANK_ROWS      = DATA_MEM_BYTES / 4;
    localparam int ROW_W          = MEM_ADDR_W - 2;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;

    // Outcome of one instruction; reg_value of a load is filled in later.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic        mem_read;
        logic [15:0] mem_address;
        logic [31:0] mem_data;
    } t_ex_result;

    // One access to the data memory.
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [31:0]           wdata;
    } t_dmem_req;

endpackage

### hw/rtl/mips_subset_single_cycle_core_unit.sv
// A result passes through the execute stage and then the output register; a lw
// also passes the memory stage, where its data memory read is registered before writeback.
// Throughput: one instruction per cycle while the output is taken; an instruction
// that follows a lw waits in the execute stage while the lw holds the memory stage.
// Reset: PC and register file clear at once; the data memory then runs a
// clearing pass over all of its rows before the first transfer.
// ----------------------------------------------------------------------------
// MIPS subset core, top level
// Executes one instruction word per input transfer and reports the next PC,
// the register write and the memory store as one output transfer.
// ----------------------------------------------------------------------------
`include "mips_subset_single_cycle_core_unit_macros.svh"

module mips_subset_single_cycle_core_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] instr
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] next_pc, [36:32] reg_index, [68:37] reg_value,
    // [84:69] mem_address, [116:85] mem_data, [119:117] zero
    output logic [119:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [0] halted, [1] reg_write, [2] mem_write
);

    // Execute stage: the accepted instruction, with its operands read from
    // the register file at the same edge.
    logic        r_s1_valid;
    logic [31:0] r_s1_instr;
    logic [31:0] r_pc;

    // Memory stage: a lw waiting for its data memory read.
    logic                 r_s2_valid;
    mscc_pkg::t_ex_result r_s2_res;

    // Output register.
    logic                 r_out_valid;
    mscc_pkg::t_ex_result r_out;

    // Most recent register write. The register file read taken when an
    // instruction is accepted misses a write at that same edge, and a lw
    // completing while the next instruction waits; this covers both.
    logic        r_wb_valid;
    logic [4:0]  r_wb_idx;
    logic [31:0] r_wb_val;

    logic                 w_in_fire;
    logic                 w_out_free;
    logic                 w_s1_fire;
    logic                 w_s2_fire;
    logic                 w_clr_done;
    logic [31:0]          w_rf_a;
    logic [31:0]          w_rf_b;
    logic [31:0]          w_a;
    logic [31:0]          w_b;
    logic [31:0]          w_ld_data;
    mscc_pkg::t_ex_result w_ex;
    mscc_pkg::t_ex_result w_s2_done;
    mscc_pkg::t_dmem_req  w_dmem_req;
    logic                 w_rf_wr_en;
    logic [4:0]           w_rf_wr_idx;
    logic [31:0]          w_rf_wr_data;

    // Handshake. An instruction in the execute stage completes when the
    // memory stage is empty and, unless it is a lw, the output register can
    // take its result; a new instruction enters as the old one completes.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_fire     = r_s1_valid && !r_s2_valid && (w_ex.mem_read || w_out_free);
    assign w_s2_fire     = r_s2_valid && w_out_free;
    assign s_axis_tready = w_clr_done && (!r_s1_valid || w_s1_fire);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_instr <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 32'd0;
        end else if (w_s1_fire) begin
            r_pc <= w_ex.next_pc;
        end
    end

    mscc_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_fire),
        .i_rs      (s_axis_tdata[25:21]),
        .i_rt      (s_axis_tdata[20:16]),
        .i_wr_en   (w_rf_wr_en),
        .i_wr_idx  (w_rf_wr_idx),
        .i_wr_data (w_rf_wr_data),
        .o_a       (w_rf_a),
        .o_b       (w_rf_b)
    );

    assign w_a = (r_wb_valid && r_wb_idx == r_s1_instr[25:21]) ? r_wb_val : w_rf_a;
    assign w_b = (r_wb_valid && r_wb_idx == r_s1_instr[20:16]) ? r_wb_val : w_rf_b;

    mscc_exec u_exec (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_ex)
    );

    // A load reads memory as it leaves the execute stage; a store writes it.
    assign w_dmem_req.rd_en = w_s1_fire && w_ex.mem_read;
    assign w_dmem_req.wr_en = w_s1_fire && w_ex.mem_write;
    assign w_dmem_req.addr  = w_ex.mem_address[mscc_pkg::MEM_ADDR_W-1:0];
    assign w_dmem_req.wdata = w_ex.mem_data;

    mscc_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dmem_req),
        .o_rdata (w_ld_data),
        .o_ready (w_clr_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_fire && w_ex.mem_read) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && w_ex.mem_read) begin
            r_s2_res <= w_ex;
        end
    end

    // A load to register zero still reports its address but no value.
    always_comb begin
        w_s2_done           = r_s2_res;
        w_s2_done.reg_value = r_s2_res.reg_write ? w_ld_data : 32'd0;
    end

    // Register writeback: the execute and memory stages never complete in
    // the same cycle, so at most one of them writes.
    always_comb begin
        if (w_s2_fire) begin
            w_rf_wr_en   = w_s2_done.reg_write;
            w_rf_wr_idx  = w_s2_done.reg_index;
            w_rf_wr_data = w_s2_done.reg_value;
        end else begin
            w_rf_wr_en   = w_s1_fire && !w_ex.mem_read && w_ex.reg_write;
            w_rf_wr_idx  = w_ex.reg_index;
            w_rf_wr_data = w_ex.reg_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (w_rf_wr_en) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rf_wr_en) begin
            r_wb_idx <= w_rf_wr_idx;
            r_wb_val <= w_rf_wr_data;
        end
    end

    // Output register, loaded by whichever stage completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_fire || (w_s1_fire && !w_ex.mem_read)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire) begin
            r_out <= w_s2_done;
        end else if (w_s1_fire && !w_ex.mem_read) begin
            r_out <= w_ex;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.mem_data, r_out.mem_address, r_out.reg_value,
                            r_out.reg_index, r_out.next_pc};
    assign m_axis_tuser  = {r_out.mem_write, r_out.reg_write, r_out.halted};

    // A lw in the memory stage must finish before the next instruction does.
    `MSCC_CHECK(a_s2_blocks_s1, r_s2_valid, !w_s1_fire, "execute completed past a pending load")
    // Nothing is in flight while the data memory is being cleared.
    `MSCC_CHECK(a_clear_idle, !w_clr_done, !r_s1_valid && !r_s2_valid && !r_out_valid,
        "instruction in flight during memory clear")
    // The halt word leaves the program counter where it was.
    `MSCC_CHECK_NEXT(a_halt_keeps_pc, w_s1_fire && w_ex.halted, r_pc == $past(r_pc),
        "halt changed the program counter")

endmodule

### hw/rtl/mscc_regfile.sv
// ----------------------------------------------------------------------------
// MIPS subset register file
// 32 x 32-bit registers, two registered reads, one write, cleared by reset.
// ----------------------------------------------------------------------------
module mscc_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_rs,
    input  logic [4:0]  i_rt,
    input  logic        i_wr_en,
    input  logic [4:0]  i_wr_idx,
    input  logic [31:0] i_wr_data,
    output logic [31:0] o_a,
    output logic [31:0] o_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic        r_a_vld;
    logic        r_b_vld;

    // An entry that has never been written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a  <= r_mem[i_rs];
            r_rd_b  <= r_mem[i_rt];
            r_a_vld <= r_valid[i_rs];
            r_b_vld <= r_valid[i_rt];
        end
    end

    assign o_a = r_a_vld ? r_rd_a : 32'd0;
    assign o_b = r_b_vld ? r_rd_b : 32'd0;

endmodule

### hw/rtl/mscc_dmem.sv
// ----------------------------------------------------------------------------
// MIPS subset data memory
// Four byte banks give big-endian word access at any byte address with
// wrap-around, plus a clearing pass after reset.
// ----------------------------------------------------------------------------
module mscc_dmem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mscc_pkg::t_dmem_req i_req,
    output logic [31:0]         o_rdata,
    output logic                o_ready
);

    logic [mscc_pkg::ROW_W-1:0] r_clr_row;
    logic                       r_clr_busy;
    logic [1:0]                 r_lo;
    logic [1:0]                 w_lo;
    logic [mscc_pkg::ROW_W-1:0] w_row_base;
    logic [7:0]                 w_rd [4];

    assign w_lo       = i_req.addr[1:0];
    assign w_row_base = i_req.addr[mscc_pkg::MEM_ADDR_W-1:2];

    // Clearing pass: one row of all four banks per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + mscc_pkg::ROW_W'(1);
            if (r_clr_row == mscc_pkg::ROW_W'(mscc_pkg::BANK_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_lo <= w_lo;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0]                 r_mem [mscc_pkg::BANK_ROWS];
        logic [7:0]                 r_rd_byte;
        logic [mscc_pkg::ROW_W-1:0] w_row;
        logic [1:0]                 w_lane;
        logic [7:0]                 w_wbyte;

        // Bytes below the start lane fall into the following row.
        assign w_row  = w_row_base + mscc_pkg::ROW_W'((2'(k) < w_lo) ? 1 : 0);
        assign w_lane = 2'(k) - w_lo;

        always_comb begin
            case (w_lane)
                2'd0:    w_wbyte = i_req.wdata[31:24];
                2'd1:    w_wbyte = i_req.wdata[23:16];
                2'd2:    w_wbyte = i_req.wdata[15:8];
                default: w_wbyte = i_req.wdata[7:0];
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (r_clr_busy) begin
                r_mem[r_clr_row] <= 8'd0;
            end else if (i_req.wr_en) begin
                r_mem[w_row] <= w_wbyte;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_req.rd_en) begin
                r_rd_byte <= r_mem[w_row];
            end
        end

        assign w_rd[k] = r_rd_byte;
    end

    // Byte i of the word came from bank (start lane + i).
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[31-8*i -: 8] = w_rd[2'(r_lo + 2'(i))];
        end
    end

    assign o_ready = !r_clr_busy;

endmodule

### hw/rtl/mscc_exec.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// Decodes one instruction and computes its next PC, register write and
// memory access from the current PC and the two source operands.
// ----------------------------------------------------------------------------
module mscc_exec (
    input  logic [31:0]          i_instr,
    input  logic [31:0]          i_pc,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output mscc_pkg::t_ex_result o_res
);

    logic [5:0]  w_op;
    logic [4:0]  w_rt;
    logic [4:0]  w_rd;
    logic [5:0]  w_fn;
    logic [31:0] w_imm;
    logic [31:0] w_pc4;
    logic [31:0] w_ea;

    assign w_op  = i_instr[31:26];
    assign w_rt  = i_instr[20:16];
    assign w_rd  = i_instr[15:11];
    assign w_fn  = i_instr[5:0];
    assign w_imm = {{16{i_instr[15]}}, i_instr[15:0]};
    assign w_pc4 = i_pc + 32'd4;
    assign w_ea  = i_a + w_imm;

    always_comb begin
        o_res         = '0;
        o_res.next_pc = w_pc4;
        if (i_instr == mscc_pkg::HALT_WORD) begin
            o_res.next_pc = i_pc;
            o_res.halted  = 1'b1;
        end else begin
            case (w_op)
                mscc_pkg::OP_RTYPE: begin
                    o_res.reg_index = w_rd;
                    o_res.reg_write = 1'b1;
                    case (w_fn)
                        mscc_pkg::FN_ADDU: o_res.reg_value = i_a + i_b;
                        mscc_pkg::FN_SUBU: o_res.reg_value = i_a - i_b;
                        mscc_pkg::FN_AND:  o_res.reg_value = i_a & i_b;
                        mscc_pkg::FN_OR:   o_res.reg_value = i_a | i_b;
                        mscc_pkg::FN_NOR:  o_res.reg_value = ~(i_a | i_b);
                        default:           o_res.reg_write = 1'b0;
                    endcase
                end
                mscc_pkg::OP_ADDIU: begin
                    o_res.reg_write = 1'b1;
                    o_res.reg_index = w_rt;
                    o_res.reg_value = w_ea;
                end
                mscc_pkg::OP_LW: begin
                    o_res.reg_write   = 1'b1;
                    o_res.reg_index   = w_rt;
                    o_res.mem_read    = 1'b1;
                    o_res.mem_address = 16'(w_ea[mscc_pkg::MEM_ADDR_W-1:0]);
                end
                mscc_pkg::OP_SW: begin
                    o_res.mem_write   = 1'b1;
                    o_res.mem_address = 16'(w_ea[mscc_pkg::MEM_ADDR_W-1:0]);
                    o_res.mem_data    = i_b;
                end
                mscc_pkg::OP_BEQ: begin
                    if (i_a == i_b) begin
                        o_res.next_pc = w_pc4 + {w_imm[29:0], 2'b00};
                    end
                end
                mscc_pkg::OP_J: begin
                    o_res.next_pc = {w_pc4[31:28], i_instr[25:0], 2'b00};
                end
                default: begin
                    o_res.next_pc = w_pc4;
                end
            endcase
            // Register zero is never written.
            if (!o_res.reg_write || o_res.reg_index == 5'd0) begin
                o_res.reg_write = 1'b0;
                o_res.reg_index = 5'd0;
                o_res.reg_value = 32'd0;
            end
        end
    end

endmodule
